// ===== src/totp_pkg.sv =====
// ----------------------------------------------------------------------------
// TOTP engine package
// Shared opcodes, status codes, SHA-1 and TOTP constants and a helper function.
// ----------------------------------------------------------------------------
package totp_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR    = 2'd0,
    OP_KEY_CHAR = 2'd1,
    OP_GENERATE = 2'd2,
    OP_VERIFY   = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_RSVD     = 2'd3
  } status_e;

  localparam logic [159:0] SHA1_IV =
    160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;
  localparam logic [19:0] CODE_MOD = 20'd1000000;
  localparam logic [63:0] STEP_SECONDS = 64'd30;

  // Reciprocal of 30 for a 21-bit dividend: quotient = (x * DIV30_MUL) >> DIV30_SHIFT.
  localparam logic [21:0] DIV30_MUL   = 22'd2236963;
  localparam int          DIV30_SHIFT = 26;
  // Reciprocal of 15625 for a 25-bit dividend; the code modulus is 64 * 15625.
  localparam logic [26:0] MOD_MUL     = 27'd70368745;
  localparam int          MOD_SHIFT   = 40;

  // Control from the sequencer to the SHA-1 round unit.
  typedef struct packed {
    logic        start;   // load chaining value into working registers
    logic        step;    // run one round with the given word
    logic        finish;  // add working registers into chaining value
    logic        init;    // reset chaining value to the IV
  } sha_ctl_t;

  // Decode one Base32 character; bit 5 set means the character is skipped.
  function automatic logic [5:0] b32_decode(input logic [7:0] ch);
    logic [7:0] u;
    u = ch;
    if (ch >= 8'h61 && ch <= 8'h7A) u = ch - 8'd32;
    if (u >= 8'h41 && u <= 8'h5A) return {1'b0, 5'(u - 8'h41)};
    if (u >= 8'h32 && u <= 8'h37) return {1'b0, 5'(u - 8'h32 + 8'd26)};
    return 6'b100000;
  endfunction

endpackage

// ===== src/totp_hmac_sha1_code_engine.sv =====
// ----------------------------------------------------------------------------
// TOTP HMAC-SHA1 code engine
// Loads a Base32 secret and produces or checks six-digit time-based codes.
// ----------------------------------------------------------------------------
// Clear and key-character transactions are handled as they are accepted
// and give no result. Generate and verify run HMAC-SHA1 as four 64-byte
// SHA-1 compressions on one shared round unit. Each compression has a
// start step, sixteen word loads (four key store reads plus a wait for
// the registered read data), 80 rounds and a finish step. Around them sit
// a setup step, division of the timestamp by 30 in four steps (16 bits per
// cycle by reciprocal multiplication), a truncation step, modulo in two
// steps by reciprocal multiplication and an output step; a verify runs
// this sequence for three windows. An empty or overflowed key answers on
// the cycle after acceptance. The block handles one transaction at a time;
// a result waits in an output register until taken, and no new transaction
// is accepted meanwhile. The key store needs no clearing after reset,
// because bytes at or past the key length are never used.
// ----------------------------------------------------------------------------
module totp_hmac_sha1_code_engine #(
  parameter int KEY_BYTES = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // tdata: opcode[1:0], key_char[9:2], timestamp[73:10],
  //        candidate_code[93:74], zero fill [95:94]
  input  logic [95:0]  s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // tdata: code[19:0], status[21:20], match[22], zero fill [23]
  output logic [23:0]  m_axis_tdata_o
);

  localparam int AW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
  localparam int MW = $clog2(KEY_BYTES) > 0 ? $clog2(KEY_BYTES) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_BLK_START, S_LOAD, S_ROUND, S_BLK_END,
    S_TRUNC, S_MOD, S_MOD_SUB, S_NEXT, S_OUT
  } state_e;

  // Input fields.
  logic [1:0]  in_op;
  logic [7:0]  in_char;
  logic [63:0] in_ts;
  logic [19:0] in_cand;
  assign in_op   = s_axis_tdata_i[1:0];
  assign in_char = s_axis_tdata_i[9:2];
  assign in_ts   = s_axis_tdata_i[73:10];
  assign in_cand = s_axis_tdata_i[93:74];

  // Key state.
  logic [6:0]  key_len_q;
  logic [11:0] acc_q;
  logic [3:0]  pend_q;
  logic        ovf_q;

  state_e      state_q;
  logic [1:0]  op_q;
  logic [19:0] cand_q;
  logic [63:0] ts_q;
  logic [1:0]  win_q;        // verify window: 0 minus, 1 zero, 2 plus
  logic [63:0] quo_q;
  logic [4:0]  rem_q;
  logic [1:0]  div_cnt_q;
  logic [1:0]  blk_q;        // 0 inner key, 1 inner tail, 2 outer key, 3 outer tail
  logic [6:0]  rnd_q;
  logic [2:0]  ld_q;         // load cycle within a word
  logic [31:0] wacc_q;
  logic [159:0] inner_q;
  logic [30:0] bin_q;
  logic [11:0] modq_q;
  logic [19:0] mrem_q;
  logic [19:0] code_q;
  logic        match_q;
  logic [19:0] out_code_q;
  logic [1:0]  out_status_q;
  logic        out_match_q;
  logic        out_valid_q;

  totp_pkg::sha_ctl_t ctl;
  logic [159:0] digest;
  logic [31:0]  word;

  // Key store access.
  logic          kwe;
  logic [AW-1:0] kwaddr, kraddr;
  logic [7:0]    kwdata, krdata;
  logic [5:0]    dec;
  logic [11:0]   acc_next;
  logic [3:0]    pend_next;

  assign dec       = totp_pkg::b32_decode(in_char);
  assign acc_next  = {acc_q[6:0], dec[4:0]};
  assign pend_next = pend_q + 4'd5;
  assign kwe = s_axis_tvalid_i && s_axis_tready_o && in_op == totp_pkg::OP_KEY_CHAR
               && !dec[5] && pend_next >= 4'd8 && key_len_q < 7'(KEY_BYTES);
  assign kwaddr = AW'(key_len_q);
  assign kwdata = 8'(acc_next >> (pend_next - 4'd8));

  // Read address: word within a block, byte within the word. The data of
  // the previous cycle's address arrives now, so the message byte is built
  // from the registered index.
  logic [5:0] byte_idx;
  logic [5:0] prev_idx_q;
  assign byte_idx = {rnd_q[3:0], ld_q[1:0]};
  assign kraddr   = AW'(byte_idx);

  totp_key_mem #(.KeyBytes(1 << MW)) u_key_mem (
    .clk_i   (clk_i),
    .we_i    (kwe),
    .waddr_i (MW'(kwaddr)),
    .wdata_i (kwdata),
    .raddr_i (MW'(kraddr)),
    .rdata_o (krdata)
  );

  // Padded message byte for the registered byte index.
  logic [7:0]  key_byte, pad_byte, tail_byte, msg_byte;
  logic [63:0] ctr;
  logic [5:0]  ctr_sh;
  logic [7:0]  dig_sel;
  assign ctr = quo_q;
  assign ctr_sh = 6'(7 - prev_idx_q[2:0]) << 3;
  assign dig_sel = 8'(inner_q >> ((6'd19 - prev_idx_q) * 8));
  // Key bytes at or past key_length read as zero.
  assign key_byte = ({1'b0, prev_idx_q} < key_len_q) ? krdata : 8'h00;
  assign pad_byte = key_byte ^ ((blk_q == 2'd0) ? 8'h36 : 8'h5C);
  always_comb begin
    tail_byte = 8'h00;
    if (blk_q == 2'd1) begin
      if (prev_idx_q < 6'd8) tail_byte = 8'(ctr >> ctr_sh);
      else if (prev_idx_q == 6'd8) tail_byte = 8'h80;
      else if (prev_idx_q == 6'd62) tail_byte = 8'h02;
      else if (prev_idx_q == 6'd63) tail_byte = 8'h40;
    end else begin
      if (prev_idx_q < 6'd20) tail_byte = dig_sel;
      else if (prev_idx_q == 6'd20) tail_byte = 8'h80;
      else if (prev_idx_q == 6'd62) tail_byte = 8'h02;
      else if (prev_idx_q == 6'd63) tail_byte = 8'hA0;
    end
  end
  logic key_blk;
  assign key_blk  = (blk_q == 2'd0) || (blk_q == 2'd2);
  assign msg_byte = key_blk ? pad_byte : tail_byte;

  // Truncation byte select from the final digest.
  logic [3:0]  off;
  logic [31:0] trunc;
  assign off   = digest[3:0];
  assign trunc = 32'(digest >> (8'd128 - {off, 3'b000}));

  // Controls for the round unit.
  always_comb begin
    ctl = '0;
    ctl.init   = (state_q == S_BLK_START) && (blk_q == 2'd0 || blk_q == 2'd2);
    ctl.start  = (state_q == S_LOAD) && rnd_q == 7'd0 && ld_q == 3'd0 && !ctl.init;
    ctl.step   = (state_q == S_ROUND);
    ctl.finish = (state_q == S_BLK_END);
  end
  assign word = wacc_q;

  totp_sha1_core u_sha1 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .round_i  (rnd_q),
    .word_i   (word),
    .digest_o (digest)
  );

  assign s_axis_tready_o = (state_q == S_IDLE) && !out_valid_q;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_match_q, out_status_q, out_code_q};

  // Division by 30, sixteen timestamp bits per step.
  logic [20:0] div_v;
  logic [42:0] div_prod;
  logic [15:0] div_qd;
  logic [4:0]  div_r;
  assign div_v    = {rem_q, ts_q[63:48]};
  assign div_prod = 43'(div_v) * 43'(totp_pkg::DIV30_MUL);
  assign div_qd   = div_prod[totp_pkg::DIV30_SHIFT +: 16];
  assign div_r    = 5'(div_v - 21'(div_qd) * 21'(totp_pkg::STEP_SECONDS));

  // Quotient by 1000000: drop the six low bits, then divide by 15625.
  logic [51:0] mod_prod;
  assign mod_prod = 52'(bin_q[30:6]) * 52'(totp_pkg::MOD_MUL);

  // Timestamp of the current window.
  logic [63:0] base_ts_q;
  logic [63:0] win_ts;
  always_comb begin
    unique case (win_q)
      2'd0:    win_ts = base_ts_q - totp_pkg::STEP_SECONDS;
      2'd2:    win_ts = base_ts_q + totp_pkg::STEP_SECONDS;
      default: win_ts = base_ts_q;
    endcase
  end

  // Sequencer, key state and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      key_len_q <= '0; acc_q <= '0; pend_q <= '0; ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
      op_q <= '0; cand_q <= '0; ts_q <= '0; base_ts_q <= '0; win_q <= '0;
      quo_q <= '0; rem_q <= '0; div_cnt_q <= '0; blk_q <= '0; rnd_q <= '0;
      ld_q <= '0; wacc_q <= '0; inner_q <= '0; bin_q <= '0;
      modq_q <= '0; mrem_q <= '0; code_q <= '0; match_q <= 1'b0;
      out_code_q <= '0; out_status_q <= '0; out_match_q <= 1'b0;
      prev_idx_q <= '0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) out_valid_q <= 1'b0;
      prev_idx_q <= byte_idx;
      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i && s_axis_tready_o) begin
            op_q <= in_op; cand_q <= in_cand; base_ts_q <= in_ts;
            match_q <= 1'b0;
            unique case (totp_pkg::opcode_e'(in_op))
              totp_pkg::OP_CLEAR: begin
                key_len_q <= '0; acc_q <= '0; pend_q <= '0; ovf_q <= 1'b0;
              end
              totp_pkg::OP_KEY_CHAR: begin
                if (!dec[5]) begin
                  acc_q <= acc_next;
                  if (pend_next >= 4'd8) begin
                    pend_q <= pend_next - 4'd8;
                    if (key_len_q >= 7'(KEY_BYTES)) ovf_q <= 1'b1;
                    else key_len_q <= key_len_q + 7'd1;
                  end else begin
                    pend_q <= pend_next;
                  end
                end
              end
              default: begin
                if (ovf_q || key_len_q == '0) begin
                  out_code_q   <= '0;
                  out_status_q <= ovf_q ? totp_pkg::ST_OVERFLOW : totp_pkg::ST_EMPTY;
                  out_match_q  <= 1'b0;
                  out_valid_q  <= 1'b1;
                end else begin
                  win_q <= (in_op == totp_pkg::OP_VERIFY) ? 2'd0 : 2'd1;
                  state_q <= S_NEXT;
                end
              end
            endcase
          end
        end
        S_NEXT: begin
          ts_q <= win_ts; rem_q <= '0; div_cnt_q <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          // One 16-bit quotient digit per cycle, most significant first.
          ts_q <= {ts_q[47:0], 16'h0000};
          rem_q <= div_r;
          quo_q <= {quo_q[47:0], div_qd};
          div_cnt_q <= div_cnt_q + 2'd1;
          if (div_cnt_q == 2'd3) begin
            blk_q <= 2'd0; state_q <= S_BLK_START;
          end
        end
        S_BLK_START: begin
          rnd_q <= '0; ld_q <= '0;
          if (blk_q == 2'd2) inner_q <= digest;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          // Four reads, then a wait for the last byte to arrive.
          if (ld_q != 3'd0) wacc_q <= {wacc_q[23:0], msg_byte};
          if (ld_q == 3'd4) begin
            ld_q <= '0;
            state_q <= S_ROUND;
          end else begin
            ld_q <= ld_q + 3'd1;
          end
        end
        S_ROUND: begin
          rnd_q <= rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= S_BLK_END;
          else if (rnd_q < 7'd15) state_q <= S_LOAD;
        end
        S_BLK_END: begin
          blk_q <= blk_q + 2'd1;
          state_q <= (blk_q == 2'd3) ? S_TRUNC : S_BLK_START;
        end
        S_TRUNC: begin
          bin_q <= trunc[30:0];
          state_q <= S_MOD;
        end
        S_MOD: begin
          modq_q <= mod_prod[totp_pkg::MOD_SHIFT +: 12];
          state_q <= S_MOD_SUB;
        end
        S_MOD_SUB: begin
          mrem_q <= 20'(32'(bin_q) - 32'(modq_q) * 32'(totp_pkg::CODE_MOD));
          state_q <= S_OUT;
        end
        default: begin
          if (mrem_q == cand_q) match_q <= 1'b1;
          if (win_q == 2'd1) code_q <= mrem_q;
          if (op_q == totp_pkg::OP_VERIFY && win_q != 2'd2) begin
            win_q <= win_q + 2'd1;
            state_q <= S_NEXT;
          end else begin
            out_code_q   <= (win_q == 2'd1) ? mrem_q : code_q;
            out_status_q <= totp_pkg::ST_OK;
            out_match_q  <= (op_q == totp_pkg::OP_VERIFY) &&
                            (match_q || mrem_q == cand_q);
            out_valid_q  <= 1'b1;
            state_q      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== src/totp_sha1_core.sv =====
// ----------------------------------------------------------------------------
// TOTP SHA-1 round unit
// One SHA-1 round per stepped cycle, with a 16-word message schedule window.
// ----------------------------------------------------------------------------
module totp_sha1_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  totp_pkg::sha_ctl_t ctl_i,
  input  logic [6:0]        round_i,
  input  logic [31:0]       word_i,     // message word for rounds 0 to 15
  output logic [159:0]      digest_o
);

  logic [159:0] h_q, h_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  w_q [16];
  logic [31:0]  w_cur, w_new, f, k, t;

  // Schedule word: supplied for the first sixteen rounds, then expanded.
  assign w_new = {w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0]};
  assign w_cur = (round_i < 7'd16) ? word_i : {w_new[30:0], w_new[31]};

  // Round function.
  always_comb begin
    if (round_i < 7'd20) begin
      f = (b_q & c_q) | (~b_q & d_q); k = 32'h5A827999;
    end else if (round_i < 7'd40) begin
      f = b_q ^ c_q ^ d_q; k = 32'h6ED9EBA1;
    end else if (round_i < 7'd60) begin
      f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); k = 32'h8F1BBCDC;
    end else begin
      f = b_q ^ c_q ^ d_q; k = 32'hCA62C1D6;
    end
    t = {a_q[26:0], a_q[31:27]} + f + e_q + k + w_cur;
  end

  // Chaining value update.
  always_comb begin
    h_d = h_q;
    if (ctl_i.init) begin
      h_d = totp_pkg::SHA1_IV;
    end else if (ctl_i.finish) begin
      h_d = {h_q[159:128] + a_q, h_q[127:96] + b_q, h_q[95:64] + c_q,
             h_q[63:32] + d_q, h_q[31:0] + e_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q <= totp_pkg::SHA1_IV;
    end else begin
      h_q <= h_d;
    end
  end

  // Working registers and schedule window.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      {a_q, b_q, c_q, d_q, e_q} <= h_q;
    end else if (ctl_i.step) begin
      e_q <= d_q;
      d_q <= c_q;
      c_q <= {b_q[1:0], b_q[31:2]};
      b_q <= a_q;
      a_q <= t;
      for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
      w_q[15] <= w_cur;
    end
  end

  assign digest_o = h_q;

endmodule

// ===== src/totp_key_mem.sv =====
// ----------------------------------------------------------------------------
// TOTP key store
// Byte memory for the secret, one write and one registered read port.
// ----------------------------------------------------------------------------
module totp_key_mem #(
  parameter int KeyBytes = 64
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [$clog2(KeyBytes)-1:0] waddr_i,
  input  logic [7:0]                  wdata_i,
  input  logic [$clog2(KeyBytes)-1:0] raddr_i,
  output logic [7:0]                  rdata_o
);

  logic [7:0] mem_q [KeyBytes];
  logic [7:0] rdata_q;

  // Synchronous write and read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
